### hdl/sn2d_pkg.sv
// shared types, codes and constants for the 2-d simplex noise pipeline
// no dependencies; imported by every module of the block
`default_nettype none

package sn2d_pkg;

  localparam int PERM_ENTRIES = 256;

  // input item commands
  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_EVAL = 2'd1,
    CMD_GRID = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  // configuration register indexes
  localparam logic [2:0] CFG_OFFSET_X  = 3'd0;
  localparam logic [2:0] CFG_OFFSET_Z  = 3'd1;
  localparam logic [2:0] CFG_SCALE_X   = 3'd2;
  localparam logic [2:0] CFG_SCALE_Z   = 3'd3;
  localparam logic [2:0] CFG_AMPLITUDE = 3'd4;

  // skew and unskew factors, q16
  localparam logic signed [15:0] F2_Q16  = 16'sd23988;
  localparam logic [13:0]        G2_Q16  = 14'd13849;
  localparam logic signed [27:0] ONE_Q16 = 28'sd65536;

  // per-item sideband that travels beside the datapath
  typedef struct packed {
    logic        valid;
    cmd_e        cmd;
    logic [7:0]  idx;
    logic [7:0]  val;
    logic [31:0] acc;
  } side_t;

  // permutation table write
  typedef struct packed {
    logic       we;
    logic [7:0] idx;
    logic [7:0] val;
  } tbl_wr_t;

  // hash value to gradient number, d mod 12 by reciprocal multiply
  function automatic logic [3:0] grad_num(input logic [7:0] d);
    logic [18:0] prod;
    logic [4:0]  q;
    logic [7:0]  rem;
    prod = 19'(d) * 19'd171;
    q    = prod[15:11];
    rem  = d - ({3'b0, q} * 8'd12);
    return rem[3:0];
  endfunction

endpackage

`default_nettype wire

### hdl/sn2d_front.sv
// coordinate front end: grid mapping, skew and skewed cell coordinate
// stages 1 to 4 of the pipeline; uses sn2d_pkg
`default_nettype none

module sn2d_front (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [31:0]   coord_x,
  input  logic signed [31:0]   coord_z,
  input  logic [31:0]          scale_x,
  input  logic [31:0]          scale_z,
  input  logic [31:0]          offset_x,
  input  logic [31:0]          offset_z,
  input  sn2d_pkg::cmd_e       cmd1,
  output logic signed [40:0]   vx,
  output logic signed [40:0]   vz,
  output logic signed [27:0]   xl,
  output logic signed [27:0]   zl
);
  import sn2d_pkg::*;

  logic signed [63:0] px, pz;
  logic signed [31:0] cx1, cz1;
  logic signed [39:0] x2, z2, x3, z3;
  logic signed [39:0] x2_next, z2_next;
  logic signed [40:0] sxz;
  logic signed [55:0] sp;

  always_comb begin
    if (cmd1 == CMD_GRID) begin
      x2_next = {{4{px[63]}}, px[63:28]} + {16'b0, offset_x[31:8]};
      z2_next = {{4{pz[63]}}, pz[63:28]} + {16'b0, offset_z[31:8]};
    end else begin
      x2_next = {{8{cx1[31]}}, cx1};
      z2_next = {{8{cz1[31]}}, cz1};
    end
  end

  assign sxz = {x2[39], x2} + {z2[39], z2};

  always_ff @(posedge clk) begin
    if (en) begin
      px  <= 64'(coord_x) * 64'($signed({1'b0, scale_x}));
      pz  <= 64'(coord_z) * 64'($signed({1'b0, scale_z}));
      cx1 <= coord_x;
      cz1 <= coord_z;
      x2  <= x2_next;
      z2  <= z2_next;
      sp  <= 56'(sxz) * 56'(F2_Q16);
      x3  <= x2;
      z3  <= z2;
      vx  <= {x3[39], x3} + {sp[55], sp[55:16]};
      vz  <= {z3[39], z3} + {sp[55], sp[55:16]};
      xl  <= x3[27:0];
      zl  <= z3[27:0];
    end
  end

endmodule

`default_nettype wire

### hdl/sn2d_lattice.sv
// cell floor, unskew, corner offsets and two-level permutation hashing
// stages 5 to 8; table copies live here; uses sn2d_pkg
`default_nettype none

module sn2d_lattice (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [40:0]   vx,
  input  logic signed [40:0]   vz,
  input  logic signed [27:0]   xl,
  input  logic signed [27:0]   zl,
  input  sn2d_pkg::tbl_wr_t    wr5,
  input  sn2d_pkg::tbl_wr_t    wr7,
  output logic [7:0]           d0,
  output logic [7:0]           d1,
  output logic [7:0]           d2,
  output logic signed [27:0]   dx0,
  output logic signed [27:0]   dz0,
  output logic signed [27:0]   dx1,
  output logic signed [27:0]   dz1,
  output logic signed [27:0]   dx2,
  output logic signed [27:0]   dz2
);
  import sn2d_pkg::*;

  // one table copy per read port, each written in step with its readers
  logic [7:0] tab_j0 [PERM_ENTRIES];
  logic [7:0] tab_j1 [PERM_ENTRIES];
  logic [7:0] tab_h0 [PERM_ENTRIES];
  logic [7:0] tab_h1 [PERM_ENTRIES];
  logic [7:0] tab_h2 [PERM_ENTRIES];

  logic [27:0]        i5, j5, i5_next, j5_next, i6, t6;
  logic [11:0]        jl6;
  logic signed [27:0] x5, z5, x6, z6, x7, z7;
  logic [7:0]         pj0, pj1, a0, a1, a2;
  logic               i1, i1_7;
  logic signed [27:0] x0_next, z0_next;

  // floor with the quirk: zero and negative integers drop by one
  always_comb begin
    i5_next = {{3{vx[40]}}, vx[40:16]};
    j5_next = {{3{vz[40]}}, vz[40:16]};
    if ((vx[40] || vx == '0) && vx[15:0] == 16'd0) i5_next = i5_next - 28'd1;
    if ((vz[40] || vz == '0) && vz[15:0] == 16'd0) j5_next = j5_next - 28'd1;
  end

  assign x0_next = x6 - $signed({i6[11:0], 16'b0} - t6);
  assign z0_next = z6 - $signed({jl6, 16'b0} - t6);

  assign i1 = x0_next > z0_next;

  always_ff @(posedge clk) begin
    if (en) begin
      i5  <= i5_next;
      j5  <= j5_next;
      x5  <= xl;
      z5  <= zl;
      i6  <= i5;
      jl6 <= j5[11:0];
      t6  <= 28'((i5 + j5) * G2_Q16);
      x6  <= x5;
      z6  <= z5;
      pj0 <= tab_j0[j5[7:0]];
      pj1 <= tab_j1[j5[7:0] + 8'd1];
      if (wr5.we) begin
        tab_j0[wr5.idx] <= wr5.val;
        tab_j1[wr5.idx] <= wr5.val;
      end
      x7   <= x0_next;
      z7   <= z0_next;
      i1_7 <= i1;
      a0   <= i6[7:0] + pj0;
      a1   <= i6[7:0] + {7'b0, i1} + (i1 ? pj0 : pj1);
      a2   <= i6[7:0] + 8'd1 + pj1;
      d0   <= tab_h0[a0];
      d1   <= tab_h1[a1];
      d2   <= tab_h2[a2];
      if (wr7.we) begin
        tab_h0[wr7.idx] <= wr7.val;
        tab_h1[wr7.idx] <= wr7.val;
        tab_h2[wr7.idx] <= wr7.val;
      end
      dx0 <= x7;
      dz0 <= z7;
      dx1 <= x7 - (i1_7 ? ONE_Q16 : 28'sd0) + $signed({14'b0, G2_Q16});
      dz1 <= z7 - (i1_7 ? 28'sd0 : ONE_Q16) + $signed({14'b0, G2_Q16});
      dx2 <= x7 - ONE_Q16 + $signed({13'b0, G2_Q16, 1'b0});
      dz2 <= z7 - ONE_Q16 + $signed({13'b0, G2_Q16, 1'b0});
    end
  end

endmodule

`default_nettype wire

### hdl/sn2d_corner.sv
// one simplex corner: gradient dot, falloff and its fourth power
// stages 9 to 13; uses sn2d_pkg
`default_nettype none

module sn2d_corner (
  input  logic                 clk,
  input  logic                 en,
  input  logic [7:0]           d,
  input  logic signed [27:0]   dx,
  input  logic signed [27:0]   dz,
  output logic signed [62:0]   term
);
  import sn2d_pkg::*;

  logic [3:0]         g;
  logic signed [29:0] dot_next, dot9, dot10, dot11, dot12;
  logic signed [55:0] sqx, sqz;
  logic signed [57:0] fall;
  logic [31:0]        a10, a2_11, a4_12;
  logic [63:0]        aa, a2a2;
  logic signed [29:0] sx, sz;

  assign g  = grad_num(d);
  assign sx = {{2{dx[27]}}, dx};
  assign sz = {{2{dz[27]}}, dz};

  // gradients: x is +-1 for the first eight, z is +-1 for 0..3 and 8..11
  always_comb begin
    case (g)
      4'd0:    dot_next = sx + sz;
      4'd1:    dot_next = sz - sx;
      4'd2:    dot_next = sx - sz;
      4'd3:    dot_next = -sx - sz;
      4'd4,
      4'd6:    dot_next = sx;
      4'd5,
      4'd7:    dot_next = -sx;
      4'd8,
      4'd10:   dot_next = sz;
      4'd9,
      4'd11:   dot_next = -sz;
      default: dot_next = '0;
    endcase
  end

  assign fall = 58'sd2147483648 - {{2{sqx[55]}}, sqx} - {{2{sqz[55]}}, sqz};
  assign aa   = {32'b0, a10} * {32'b0, a10};
  assign a2a2 = {32'b0, a2_11} * {32'b0, a2_11};

  always_ff @(posedge clk) begin
    if (en) begin
      sqx   <= 56'(dx) * 56'(dx);
      sqz   <= 56'(dz) * 56'(dz);
      dot9  <= dot_next;
      a10   <= fall[57] ? 32'd0 : fall[31:0];
      dot10 <= dot9;
      a2_11 <= aa[63:32];
      dot11 <= dot10;
      a4_12 <= a2a2[63:32];
      dot12 <= dot11;
      term  <= 63'($signed({1'b0, a4_12})) * 63'(dot12);
    end
  end

endmodule

`default_nettype wire

### hdl/simplex_noise_2d.sv
// two-dimensional fixed-point simplex noise, top level
// uses sn2d_pkg, sn2d_front, sn2d_lattice and sn2d_corner
//
// items enter on item_valid / item_stall and leave on result_valid /
// result_stall; an item moves when valid is high and stall is low.
// command load writes one permutation table entry, evaluate returns the
// q16.16 noise at coord_x / coord_z, grid maps the coordinate through
// scale and offset and returns accum_in plus amplitude times noise,
// saturated. every item, load included, returns exactly one result.
// the pipeline has 17 register stages; one item is taken every cycle
// while item_stall is low.
// the table is read at five places per item, so it is held in five
// copies; a load writes each copy when it passes that copy's read stage,
// which keeps loads and reads in item order.
// when result_stall holds a waiting result, the whole pipeline freezes
// and item_stall goes high; nothing is dropped or repeated.
// configuration is written through cfg_we / cfg_index / cfg_data while
// no item is in flight. reset clears the valid bits and presets the
// config registers; the table stays undefined until loaded.
`default_nettype none

module simplex_noise_2d (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         command,
  input  logic [7:0]         table_index,
  input  logic [7:0]         table_value,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_z,
  input  logic signed [31:0] accum_in,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] result_value,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import sn2d_pkg::*;

  // configuration registers
  logic [31:0]        offset_x, offset_z, scale_x, scale_z;
  logic signed [31:0] amplitude;

  // pipeline advance: everything moves unless a result waits
  logic  en;
  side_t side [1:17];

  logic signed [40:0] vx, vz;
  logic signed [27:0] xl, zl;
  tbl_wr_t            wr5, wr7;
  logic [7:0]         d0, d1, d2;
  logic signed [27:0] dx0, dz0, dx1, dz1, dx2, dz2;
  logic signed [62:0] term0, term1, term2;

  logic signed [63:0] sum14, scaled;
  logic signed [31:0] n15, n16;
  logic signed [63:0] p16;
  logic signed [48:0] grid;
  logic signed [31:0] result_next;

  assign en           = !side[17].valid || !result_stall;
  assign item_stall   = !en;
  assign result_valid = side[17].valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x  <= 32'd0;
      offset_z  <= 32'd0;
      scale_x   <= 32'h1000_0000;
      scale_z   <= 32'h1000_0000;
      amplitude <= 32'sh0001_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET_X:  offset_x  <= cfg_data;
        CFG_OFFSET_Z:  offset_z  <= cfg_data;
        CFG_SCALE_X:   scale_x   <= cfg_data;
        CFG_SCALE_Z:   scale_z   <= cfg_data;
        CFG_AMPLITUDE: amplitude <= cfg_data;
        default: ;
      endcase
    end
  end

  // sideband shift line beside the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 17; k++) side[k].valid <= 1'b0;
    end else if (en) begin
      side[1].valid <= item_valid;
      side[1].cmd   <= cmd_e'(command);
      side[1].idx   <= table_index;
      side[1].val   <= table_value;
      side[1].acc   <= accum_in;
      for (int k = 2; k <= 17; k++) side[k] <= side[k-1];
    end
  end

  // table writes, one per read stage
  always_comb begin
    wr5.we  = en && side[5].valid && side[5].cmd == CMD_LOAD;
    wr5.idx = side[5].idx;
    wr5.val = side[5].val;
    wr7.we  = en && side[7].valid && side[7].cmd == CMD_LOAD;
    wr7.idx = side[7].idx;
    wr7.val = side[7].val;
  end

  sn2d_front u_front (
    .clk      (clk),
    .en       (en),
    .coord_x  (coord_x),
    .coord_z  (coord_z),
    .scale_x  (scale_x),
    .scale_z  (scale_z),
    .offset_x (offset_x),
    .offset_z (offset_z),
    .cmd1     (side[1].cmd),
    .vx       (vx),
    .vz       (vz),
    .xl       (xl),
    .zl       (zl)
  );

  sn2d_lattice u_lattice (
    .clk (clk),
    .en  (en),
    .vx  (vx),
    .vz  (vz),
    .xl  (xl),
    .zl  (zl),
    .wr5 (wr5),
    .wr7 (wr7),
    .d0  (d0),
    .d1  (d1),
    .d2  (d2),
    .dx0 (dx0),
    .dz0 (dz0),
    .dx1 (dx1),
    .dz1 (dz1),
    .dx2 (dx2),
    .dz2 (dz2)
  );

  sn2d_corner u_corner0 (.clk(clk), .en(en), .d(d0), .dx(dx0), .dz(dz0), .term(term0));
  sn2d_corner u_corner1 (.clk(clk), .en(en), .d(d1), .dx(dx1), .dz(dz1), .term(term1));
  sn2d_corner u_corner2 (.clk(clk), .en(en), .d(d2), .dx(dx2), .dz(dz2), .term(term2));

  // times 70 as shifts and adds
  assign scaled = (sum14 <<< 6) + (sum14 <<< 2) + (sum14 <<< 1);

  // grid sum, wide enough to see overflow before saturating
  assign grid = {{17{side[16].acc[31]}}, side[16].acc} + {p16[63], p16[63:16]};

  always_comb begin
    case (side[16].cmd)
      CMD_EVAL: result_next = n16;
      CMD_GRID: begin
        if (grid > 49'sd2147483647)       result_next = 32'sh7fff_ffff;
        else if (grid < -49'sd2147483648) result_next = 32'sh8000_0000;
        else                              result_next = grid[31:0];
      end
      default:  result_next = 32'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum14 <= {term0[62], term0} + {term1[62], term1} + {term2[62], term2};
      n15   <= scaled[63:32];
      n16   <= n15;
      p16   <= 64'(n15) * 64'(amplitude);
      result_value <= result_next;
    end
  end

endmodule

`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the simplex_noise_2d pipeline
// depends on sn2d_pkg and simplex_noise_2d; fills the table, then directed and random items
`timescale 1ns / 1ps

module tb_top;
  import sn2d_pkg::*;

  // clock, reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // item channel
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [1:0]         command = CMD_LOAD;
  logic [7:0]         table_index = '0;
  logic [7:0]         table_value = '0;
  logic signed [31:0] coord_x = '0;
  logic signed [31:0] coord_z = '0;
  logic signed [31:0] accum_in = '0;

  // result channel
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic signed [31:0] result_value;

  // config port
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  simplex_noise_2d dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // one input item
  typedef struct {
    cmd_e               cmd;
    logic [7:0]         idx;
    logic [7:0]         val;
    logic signed [31:0] x;
    logic signed [31:0] z;
    logic signed [31:0] acc;
  } noise_item_t;

  noise_item_t        pending_items[$];
  logic signed [31:0] expected_values[$];
  int                 fail_count = 0;
  bit                 drive_en = 1'b0;

  // predictor state: own table copy and registers
  logic [7:0]  perm_copy[256];
  logic [31:0] off_x_reg, off_z_reg, scl_x_reg, scl_z_reg, amp_reg;

  // gradient components, x then z for each of the 12 directions
  function automatic longint grad_dot(int g, longint dx, longint dz);
    int gx, gz;
    case (g)
      0: begin gx = 1;  gz = 1;  end
      1: begin gx = -1; gz = 1;  end
      2: begin gx = 1;  gz = -1; end
      3: begin gx = -1; gz = -1; end
      4: begin gx = 1;  gz = 0;  end
      5: begin gx = -1; gz = 0;  end
      6: begin gx = 1;  gz = 0;  end
      7: begin gx = -1; gz = 0;  end
      8: begin gx = 0;  gz = 1;  end
      9: begin gx = 0;  gz = -1; end
      10: begin gx = 0; gz = 1;  end
      default: begin gx = 0; gz = -1; end
    endcase
    return gx * dx + gz * dz;
  endfunction

  // falloff^4 times dot, q.48
  function automatic longint corner_term(longint dx, longint dz, int g);
    longint a;
    longint unsigned a2, a4;
    a = 64'sh8000_0000 - dx * dx - dz * dz;
    if (a < 0) return 0;
    a2 = (longint'(a) * longint'(a)) >> 32;
    a4 = (a2 * a2) >> 32;
    return longint'(a4) * grad_dot(g, dx, dz);
  endfunction

  // floor to integer, zero and negative integers drop one more
  function automatic longint cell_floor(longint v);
    longint q;
    q = v >>> 16;
    if (v <= 0 && v[15:0] == 16'd0) q = q - 1;
    return q;
  endfunction

  function automatic int hash_grad(longint k);
    return perm_copy[k[7:0]] % 12;
  endfunction

  function automatic longint simplex_at(longint x, longint z);
    longint s, i, j, t, x0, z0, x1, z1, x2, z2, sum;
    longint ii, jj, i1, j1;
    s  = ((x + z) * 23988) >>> 16;
    i  = cell_floor(x + s);
    j  = cell_floor(z + s);
    t  = (i + j) * 13849;
    x0 = x - (i * 65536 - t);
    z0 = z - (j * 65536 - t);
    i1 = (x0 > z0) ? 1 : 0;
    j1 = 1 - i1;
    x1 = x0 - i1 * 65536 + 13849;
    z1 = z0 - j1 * 65536 + 13849;
    x2 = x0 - 65536 + 2 * 13849;
    z2 = z0 - 65536 + 2 * 13849;
    ii = i & 255;
    jj = j & 255;
    sum = corner_term(x0, z0, hash_grad(ii + perm_copy[jj[7:0]]))
        + corner_term(x1, z1, hash_grad(ii + i1 + perm_copy[8'(jj + j1)]))
        + corner_term(x2, z2, hash_grad(ii + 1 + perm_copy[8'(jj + 1)]));
    return (sum * 70) >>> 32;
  endfunction

  function automatic logic signed [31:0] predict_result(noise_item_t it);
    longint gx, gz, n, total;
    case (it.cmd)
      CMD_LOAD: begin
        perm_copy[it.idx] = it.val;
        return 0;
      end
      CMD_EVAL: return 32'(simplex_at(longint'(it.x), longint'(it.z)));
      CMD_GRID: begin
        gx = ((longint'(it.x) * longint'({32'd0, scl_x_reg})) >>> 28)
             + longint'({32'd0, off_x_reg} >> 8);
        gz = ((longint'(it.z) * longint'({32'd0, scl_z_reg})) >>> 28)
             + longint'({32'd0, off_z_reg} >> 8);
        n = simplex_at(gx, gz);
        total = longint'(it.acc) + ((n * longint'($signed(amp_reg))) >>> 16);
        if (total > 64'sd2147483647) total = 64'sd2147483647;
        if (total < -64'sd2147483648) total = -64'sd2147483648;
        return 32'(total);
      end
      default: return 0;
    endcase
  endfunction

  // mostly short gaps, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // driver: inputs move at the falling edge
  int     send_gap = 0;
  bit     gaps_on = 1'b1;
  bit     in_taken = 1'b0;
  longint accepted = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        // handshake happened at the rising edge just gone
        accepted++;
        send_gap = gaps_on ? gap_len() : 0;
      end
      if (item_valid && !in_taken) begin
        // hold payload
      end else if (drive_en && pending_items.size() > 0 && send_gap == 0) begin
        item_valid  <= 1'b1;
        command     <= pending_items[0].cmd;
        table_index <= pending_items[0].idx;
        table_value <= pending_items[0].val;
        coord_x     <= pending_items[0].x;
        coord_z     <= pending_items[0].z;
        accum_in    <= pending_items[0].acc;
      end else begin
        item_valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end
      result_stall <= gaps_on ? (gap_len() > 0) : 1'b0;
    end
  end

  // predictor fed at the accepting edge
  always @(posedge clk) begin
    in_taken = !rst && item_valid && !item_stall;
    if (in_taken) begin
      expected_values.push_back(predict_result(pending_items[0]));
      void'(pending_items.pop_front());
    end
  end

  // monitor: results sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_values.size() == 0) begin
        $error("unexpected result_value %0d", result_value);
        fail_count++;
      end else begin
        if (result_value !== expected_values[0]) begin
          $error("result_value expected %0d actual %0d", expected_values[0], result_value);
          fail_count++;
        end
        void'(expected_values.pop_front());
      end
    end
  end

  task automatic add_item(cmd_e c, logic [7:0] i, logic [7:0] v,
                          logic [31:0] x, logic [31:0] z, logic [31:0] a);
    noise_item_t it;
    it.cmd = c; it.idx = i; it.val = v; it.x = x; it.z = z; it.acc = a;
    pending_items.push_back(it);
  endtask

  // write one register; only called when idle
  task automatic write_cfg(logic [2:0] r, logic [31:0] d);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= r; cfg_data <= d;
    case (r)
      CFG_OFFSET_X: off_x_reg = d;
      CFG_OFFSET_Z: off_z_reg = d;
      CFG_SCALE_X:  scl_x_reg = d;
      CFG_SCALE_Z:  scl_z_reg = d;
      CFG_AMPLITUDE: amp_reg = d;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until everything queued is accepted and answered
  task automatic drain();
    while (pending_items.size() > 0 || expected_values.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();                                // any value
      1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      2: return {16'($urandom_range(0, 40) - 20), 16'h0000};   // integer
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0: add_item(CMD_LOAD, 8'($urandom()), 8'($urandom()), $urandom(), $urandom(),
                    $urandom());
        1: add_item(CMD_NONE, 8'($urandom()), 8'($urandom()), $urandom(), $urandom(),
                    $urandom());
        2, 3, 4, 5, 6, 7, 8, 9:
          add_item(CMD_EVAL, 8'($urandom()), 8'($urandom()), rand_coord(), rand_coord(),
                   $urandom());
        default:
          add_item(CMD_GRID, 8'($urandom()), 8'($urandom()), rand_coord(), rand_coord(),
                   $urandom_range(0, 1) ? $urandom() : 32'($signed($urandom_range(0, 400000)) - 200000));
      endcase
    end
  endtask

  initial begin
    off_x_reg = 0; off_z_reg = 0;
    scl_x_reg = 32'h1000_0000; scl_z_reg = 32'h1000_0000;
    amp_reg = 32'h0001_0000;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill the whole table first so no read hits an unwritten entry
    for (int k = 0; k < 256; k++)
      add_item(CMD_LOAD, 8'(k), 8'($urandom()), $urandom(), $urandom(), $urandom());
    drive_en = 1'b1;

    // directed: extremes, integers and zero for the floor quirk, unused command
    add_item(CMD_EVAL, 8'h00, 8'h00, 32'd0, 32'd0, 32'd0);
    add_item(CMD_EVAL, 8'hFF, 8'hFF, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_FFFF);
    add_item(CMD_EVAL, 8'h00, 8'h00, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    add_item(CMD_EVAL, 8'h00, 8'h00, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    add_item(CMD_EVAL, 8'h00, 8'h00, 32'h8000_0000, 32'h8000_0000, 32'd0);
    add_item(CMD_EVAL, 8'h00, 8'h00, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
    add_item(CMD_EVAL, 8'h00, 8'h00, 32'hFFFD_0000, 32'h0000_8000, 32'd0);
    add_item(CMD_EVAL, 8'h00, 8'h00, 32'h0000_4000, 32'h0000_2000, 32'd0);
    add_item(CMD_GRID, 8'h00, 8'h00, 32'h0003_8000, 32'h0001_4000, 32'h7FFF_FFFF);
    add_item(CMD_GRID, 8'h00, 8'h00, 32'h0000_6000, 32'hFFFF_A000, 32'h8000_0000);
    add_item(CMD_GRID, 8'h00, 8'h00, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    add_item(CMD_NONE, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(CMD_LOAD, 8'hFF, 8'h00, 32'd0, 32'd0, 32'd0);
    add_item(CMD_LOAD, 8'h00, 8'hFF, 32'd0, 32'd0, 32'd0);
    add_item(CMD_EVAL, 8'h00, 8'h00, 32'h00FF_8000, 32'h0000_0001, 32'd0);
    random_phase(400);
    // sender holds off until everything has come back
    drain();

    // extreme settings: max x scale and x offset, zero z scale, negative max amplitude
    write_cfg(CFG_OFFSET_X, 32'hFFFF_FFFF);
    write_cfg(CFG_OFFSET_Z, 32'hFF00_0000);
    write_cfg(CFG_SCALE_X, 32'hFFFF_FFFF);
    write_cfg(CFG_SCALE_Z, 32'h0000_0000);
    write_cfg(CFG_AMPLITUDE, 32'h8000_0000);
    add_item(CMD_GRID, 8'h00, 8'h00, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    add_item(CMD_GRID, 8'h00, 8'h00, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    random_phase(400);
    drain();

    write_cfg(CFG_AMPLITUDE, 32'h7FFF_FFFF);
    write_cfg(CFG_SCALE_Z, 32'hFFFF_FFFF);
    write_cfg(CFG_OFFSET_X, 32'd0);
    random_phase(400);
    drain();

    // moderate random settings, one stretch with no idling
    write_cfg(CFG_OFFSET_X, $urandom());
    write_cfg(CFG_OFFSET_Z, $urandom());
    write_cfg(CFG_SCALE_X, $urandom_range(0, 32'h3000_0000));
    write_cfg(CFG_SCALE_Z, $urandom_range(0, 32'h3000_0000));
    write_cfg(CFG_AMPLITUDE, $urandom());
    gaps_on = 1'b0;
    random_phase(300);
    drain();
    gaps_on = 1'b1;
    write_cfg(CFG_AMPLITUDE, 32'h0000_0000);
    write_cfg(CFG_SCALE_X, 32'h1000_0000);
    random_phase(300);
    drain();

    if (fail_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
